### design/pfm_pkg.sv
// Shared types, constants and helpers of the page table and frame map.
`default_nettype none

package pfm_pkg;

	// Table sizes
	localparam int MAX_PAGES  = 256;
	localparam int MAX_FRAMES = 64;
	localparam int PAGE_W     = $clog2(MAX_PAGES);
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int PCNT_W     = $clog2(MAX_PAGES + 1);
	localparam int FCNT_W     = $clog2(MAX_FRAMES + 1);

	// Free-frame search: frames per group and the number of groups
	localparam int FIND_GRP   = 8;
	localparam int FIND_NGRP  = MAX_FRAMES / FIND_GRP;

	// Configuration port
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 9;
	localparam int CFG_PAGES_W    = 9;
	localparam int CFG_FRAMES_W   = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'b1;
	localparam logic [CFG_PAGES_W-1:0]  CFG_PAGES_RST  = 9'd256;
	localparam logic [CFG_FRAMES_W-1:0] CFG_FRAMES_RST = 7'd64;

	// Beat widths
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_ASSIGN = 3'd0,
		CMD_FREE   = 3'd1,
		CMD_DIRTY  = 3'd2,
		CMD_REF    = 3'd3,
		CMD_QPAGE  = 3'd4,
		CMD_QFRAME = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK          = 2'd0,
		STAT_NO_FREE     = 2'd1,
		STAT_PAGE_RANGE  = 2'd2,
		STAT_FRAME_RANGE = 2'd3
	} status_t;

	// One page table entry (first member is the top bit)
	typedef struct packed {
		logic               present;
		logic [FRAME_W-1:0] frame;
		logic               lf_valid;
		logic [FRAME_W-1:0] last_frame;
		logic               dirty;
		logic               referenced;
	} page_entry_t;

	// Input tdata layout, lowest field last
	typedef struct packed {
		logic               pad;
		logic               auto_frame;
		logic [FRAME_W-1:0] frame;
		logic [PAGE_W-1:0]  page;
	} in_data_t;

	// Output tdata layout, lowest field last
	typedef struct packed {
		logic [FCNT_W-1:0]  free_count;
		logic               last_frame_valid;
		logic [FRAME_W-1:0] last_frame;
		logic               referenced;
		logic               dirty;
		logic               present;
		logic               mapped;
		logic [PAGE_W-1:0]  page_out;
		logic [FRAME_W-1:0] frame_out;
	} out_data_t;

	// Result of the lowest-free-frame search
	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] frame;
	} find_t;

	// Unmap a page: its current frame becomes its last frame if it was present
	function automatic page_entry_t unmap_entry(input page_entry_t e);
		page_entry_t r;
		r            = e;
		r.lf_valid   = e.present;
		r.last_frame = e.present ? e.frame : '0;
		r.present    = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

### design/pfm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/pfm_find.sv
// Two-stage search for the lowest free frame below the frame limit.
`default_nettype none

module pfm_find (
	input  wire logic                             clk,
	input  wire logic                             capture,
	input  wire logic [pfm_pkg::MAX_FRAMES-1:0]   occ,
	input  wire logic [pfm_pkg::FCNT_W-1:0]       nf,
	output pfm_pkg::find_t                        result
);

	localparam int GRP_W = $clog2(pfm_pkg::FIND_GRP);

	logic             grp_any_s1 [pfm_pkg::FIND_NGRP];
	logic [GRP_W-1:0] grp_idx_s1 [pfm_pkg::FIND_NGRP];

	// Stage 1: lowest free frame inside each group
	always_ff @(posedge clk) begin
		if (capture) begin
			for (int g = 0; g < pfm_pkg::FIND_NGRP; g++) begin
				grp_any_s1[g] <= 1'b0;
				grp_idx_s1[g] <= '0;
				for (int k = pfm_pkg::FIND_GRP - 1; k >= 0; k--) begin
					if (!occ[g*pfm_pkg::FIND_GRP + k] &&
					    (g*pfm_pkg::FIND_GRP + k) < int'(nf)) begin
						grp_any_s1[g] <= 1'b1;
						grp_idx_s1[g] <= GRP_W'(k);
					end
				end
			end
		end
	end

	// Stage 2: lowest group that has a free frame
	always_comb begin
		result = '0;
		for (int g = pfm_pkg::FIND_NGRP - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				result.found = 1'b1;
				result.frame = pfm_pkg::FRAME_W'(g*pfm_pkg::FIND_GRP + int'(grp_idx_s1[g]));
			end
		end
	end

endmodule

`default_nettype wire

### design/page_frame_map_table.sv
// Page table with frame map: one command at a time, kept in two block RAMs.
// The result beat is registered after the find, owner, victim and write steps,
// later while an earlier result beat is still waiting to be taken.
// A new command is taken only once the last one is done (page RAM read, owner
// RAM read, victim read-modify-write, page write-back through one page RAM port).
// Reset clears all tables at once; a write to the frame limit starts a
// recount of occupied frames, so no command is taken until that sweep ends.
`default_nettype none

module page_frame_map_table (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// command stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [pfm_pkg::IN_DATA_W-1:0]     s_tdata,  // page, frame, auto_frame, pad
	input  wire logic [pfm_pkg::CMD_W-1:0]         s_tuser,  // cmd
	// result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [pfm_pkg::OUT_DATA_W-1:0]         m_tdata,  // frame_out, page_out, mapped,
	                                                         // present, dirty, referenced,
	                                                         // last_frame, last_frame_valid,
	                                                         // free_count
	output logic [pfm_pkg::STATUS_W-1:0]           m_tuser,  // status
	// configuration writes
	input  wire logic                              cfg_we,
	input  wire logic [pfm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pfm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FIND  = 6'b000010,
		S_OWN   = 6'b000100,
		S_VICT  = 6'b001000,
		S_WRITE = 6'b010000,
		S_SWEEP = 6'b100000
	} state_t;

	localparam int ENTRY_W = $bits(pfm_pkg::page_entry_t);

	state_t state_q;

	// configuration and control
	logic [pfm_pkg::CFG_PAGES_W-1:0]  pages_q;
	logic [pfm_pkg::CFG_FRAMES_W-1:0] frames_q;
	logic                             pend_q;
	logic [pfm_pkg::MAX_FRAMES-1:0]   occ_q;
	logic [pfm_pkg::MAX_FRAMES-1:0]   ovalid_q;
	logic [pfm_pkg::MAX_PAGES-1:0]    pv_q;
	logic [pfm_pkg::FCNT_W-1:0]       occ_cnt_q;
	logic [pfm_pkg::FCNT_W-1:0]       sweep_cnt_q;
	logic                             m_tvalid_q;

	// command payload
	logic [pfm_pkg::CMD_W-1:0]        cmd_q;
	logic [pfm_pkg::PAGE_W-1:0]       pg_q;
	logic [pfm_pkg::FRAME_W-1:0]      fr_q;
	logic                             auto_q;
	pfm_pkg::status_t                 status_q;
	logic [pfm_pkg::FRAME_W-1:0]      tgt_q;
	pfm_pkg::page_entry_t             pd_q;
	logic                             own_v_q;
	logic [pfm_pkg::PAGE_W-1:0]       own_pg_q;
	logic                             vic_q;
	pfm_pkg::page_entry_t             vd_q;
	pfm_pkg::out_data_t               m_tdata_q;
	pfm_pkg::status_t                 m_tuser_q;

	logic [pfm_pkg::PCNT_W-1:0]       np;
	logic [pfm_pkg::FCNT_W-1:0]       nf;
	pfm_pkg::in_data_t                in_d;
	logic                             accept;
	logic                             out_free;
	pfm_pkg::find_t                   fnd;

	logic                             is_page_cmd;
	logic                             is_frame_cmd;
	logic                             page_upd;
	logic                             ok;
	pfm_pkg::status_t                 st_find;
	logic [pfm_pkg::FRAME_W-1:0]      tgt_find;
	logic                             vic_own;

	logic                             page_we;
	logic [pfm_pkg::PAGE_W-1:0]       page_waddr;
	logic [ENTRY_W-1:0]               page_wdata;
	logic [pfm_pkg::PAGE_W-1:0]       page_raddr;
	logic [ENTRY_W-1:0]               page_rdata;
	logic                             own_we;
	logic [pfm_pkg::PAGE_W-1:0]       own_rdata;

	pfm_pkg::page_entry_t             vraw;
	pfm_pkg::page_entry_t             vunm;
	pfm_pkg::page_entry_t             pnew;
	pfm_pkg::out_data_t               res;

	// effective limits
	assign np = (int'(pages_q) > pfm_pkg::MAX_PAGES) ?
	            pfm_pkg::PCNT_W'(pfm_pkg::MAX_PAGES) : pfm_pkg::PCNT_W'(pages_q);
	assign nf = (int'(frames_q) > pfm_pkg::MAX_FRAMES) ?
	            pfm_pkg::FCNT_W'(pfm_pkg::MAX_FRAMES) : pfm_pkg::FCNT_W'(frames_q);

	assign in_d     = pfm_pkg::in_data_t'(s_tdata);
	assign s_tready = (state_q == S_IDLE) && !pend_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// lowest free frame, captured with the command
	pfm_find u_find (
		.clk     (clk),
		.capture (accept),
		.occ     (occ_q),
		.nf      (nf),
		.result  (fnd)
	);

	// command decode
	assign is_page_cmd  = (cmd_q == pfm_pkg::CMD_ASSIGN) || (cmd_q == pfm_pkg::CMD_DIRTY) ||
	                      (cmd_q == pfm_pkg::CMD_REF)    || (cmd_q == pfm_pkg::CMD_QPAGE);
	assign is_frame_cmd = (cmd_q == pfm_pkg::CMD_FREE)   || (cmd_q == pfm_pkg::CMD_QFRAME);
	assign page_upd     = (cmd_q == pfm_pkg::CMD_ASSIGN) || (cmd_q == pfm_pkg::CMD_DIRTY) ||
	                      (cmd_q == pfm_pkg::CMD_REF);
	assign ok           = (status_q == pfm_pkg::STAT_OK);

	// status and target frame: page first, then frame or free space
	always_comb begin
		st_find = pfm_pkg::STAT_OK;
		if (is_page_cmd) begin
			if (pfm_pkg::PCNT_W'(pg_q) >= np) begin
				st_find = pfm_pkg::STAT_PAGE_RANGE;
			end else if (cmd_q == pfm_pkg::CMD_ASSIGN) begin
				if (auto_q) begin
					if (!fnd.found) begin
						st_find = pfm_pkg::STAT_NO_FREE;
					end
				end else if (pfm_pkg::FCNT_W'(fr_q) >= nf) begin
					st_find = pfm_pkg::STAT_FRAME_RANGE;
				end
			end
		end else if (is_frame_cmd) begin
			if (pfm_pkg::FCNT_W'(fr_q) >= nf) begin
				st_find = pfm_pkg::STAT_FRAME_RANGE;
			end
		end
	end

	assign tgt_find = ((cmd_q == pfm_pkg::CMD_ASSIGN) && auto_q) ? fnd.frame : fr_q;

	// the owner of the target frame must be unmapped
	assign vic_own = ok && ovalid_q[tgt_q] &&
	                 (((cmd_q == pfm_pkg::CMD_ASSIGN) && (own_rdata != pg_q)) ||
	                  (cmd_q == pfm_pkg::CMD_FREE));

	// victim entry as read, and unmapped
	assign vraw = pv_q[own_pg_q] ? pfm_pkg::page_entry_t'(page_rdata) : '0;
	assign vunm = pfm_pkg::unmap_entry(vraw);

	// updated entry of the command's page
	always_comb begin
		pnew = pd_q;
		unique case (cmd_q)
			pfm_pkg::CMD_ASSIGN: begin
				pnew.present    = 1'b1;
				pnew.frame      = tgt_q;
				pnew.lf_valid   = 1'b1;
				pnew.last_frame = tgt_q;
			end
			pfm_pkg::CMD_DIRTY: pnew.dirty      = 1'b1;
			pfm_pkg::CMD_REF:   pnew.referenced = 1'b1;
			default:            pnew = pd_q;
		endcase
	end

	// page RAM ports: victim write-back, then own page write-back
	assign page_we    = ((state_q == S_VICT) && vic_q) ||
	                    ((state_q == S_WRITE) && ok && page_upd);
	assign page_waddr = (state_q == S_VICT) ? own_pg_q : pg_q;
	assign page_wdata = (state_q == S_VICT) ? ENTRY_W'(vunm) : ENTRY_W'(pd_q);
	assign page_raddr = (state_q == S_OWN) ? own_rdata : in_d.page;

	pfm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (pfm_pkg::MAX_PAGES)
	) u_page_ram (
		.clk   (clk),
		.we    (page_we),
		.waddr (page_waddr),
		.wdata (page_wdata),
		.raddr (page_raddr),
		.rdata (page_rdata)
	);

	// frame owner RAM; its valid bits live in ovalid_q
	assign own_we = (state_q == S_VICT) && ok && (cmd_q == pfm_pkg::CMD_ASSIGN);

	pfm_ram #(
		.WIDTH (pfm_pkg::PAGE_W),
		.DEPTH (pfm_pkg::MAX_FRAMES)
	) u_owner_ram (
		.clk   (clk),
		.we    (own_we),
		.waddr (tgt_q),
		.wdata (pg_q),
		.raddr (tgt_find),
		.rdata (own_rdata)
	);

	// result beat
	always_comb begin
		res            = '0;
		res.free_count = nf - occ_cnt_q;
		if (ok) begin
			if (is_page_cmd) begin
				res.page_out         = pg_q;
				res.present          = pd_q.present;
				res.dirty            = pd_q.dirty;
				res.referenced       = pd_q.referenced;
				res.last_frame       = pd_q.lf_valid ? pd_q.last_frame : '0;
				res.last_frame_valid = pd_q.lf_valid;
				if (pd_q.present) begin
					res.frame_out = pd_q.frame;
					res.mapped    = 1'b1;
				end
			end else if (is_frame_cmd) begin
				res.frame_out = fr_q;
				res.mapped    = (cmd_q == pfm_pkg::CMD_QFRAME) && own_v_q;
				if (own_v_q) begin
					res.page_out         = own_pg_q;
					res.present          = vd_q.present;
					res.dirty            = vd_q.dirty;
					res.referenced       = vd_q.referenced;
					res.last_frame       = vd_q.lf_valid ? vd_q.last_frame : '0;
					res.last_frame_valid = vd_q.lf_valid;
				end
			end
		end
	end

	// sequencer, frame map and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pages_q     <= pfm_pkg::CFG_PAGES_RST;
			frames_q    <= pfm_pkg::CFG_FRAMES_RST;
			pend_q      <= 1'b0;
			occ_q       <= '0;
			ovalid_q    <= '0;
			pv_q        <= '0;
			occ_cnt_q   <= '0;
			sweep_cnt_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pend_q) begin
						state_q     <= S_SWEEP;
						sweep_cnt_q <= '0;
						occ_cnt_q   <= '0;
					end else if (s_tvalid) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: state_q <= S_OWN;
				S_OWN:  state_q <= S_VICT;
				S_VICT: begin
					if (vic_q) begin
						pv_q[own_pg_q] <= 1'b1;
					end
					if (ok && (cmd_q == pfm_pkg::CMD_ASSIGN)) begin
						occ_q[tgt_q]    <= 1'b1;
						ovalid_q[tgt_q] <= 1'b1;
						if (!occ_q[tgt_q]) begin
							occ_cnt_q <= occ_cnt_q + 1'b1;
						end
					end else if (ok && (cmd_q == pfm_pkg::CMD_FREE)) begin
						occ_q[tgt_q]    <= 1'b0;
						ovalid_q[tgt_q] <= 1'b0;
						if (occ_q[tgt_q]) begin
							occ_cnt_q <= occ_cnt_q - 1'b1;
						end
					end
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (ok && page_upd) begin
						pv_q[pg_q] <= 1'b1;
					end
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					// recount occupied frames below the new limit
					if (pend_q) begin
						sweep_cnt_q <= '0;
						occ_cnt_q   <= '0;
					end else if (sweep_cnt_q == pfm_pkg::FCNT_W'(pfm_pkg::MAX_FRAMES)) begin
						state_q <= S_IDLE;
					end else begin
						if (occ_q[sweep_cnt_q[pfm_pkg::FRAME_W-1:0]] && (sweep_cnt_q < nf)) begin
							occ_cnt_q <= occ_cnt_q + 1'b1;
						end
						sweep_cnt_q <= sweep_cnt_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// result beat: raised on the last step, dropped once taken
			if ((state_q == S_WRITE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// register writes
			if (cfg_we) begin
				if (cfg_index == pfm_pkg::CFG_PAGES) begin
					pages_q <= cfg_data[pfm_pkg::CFG_PAGES_W-1:0];
				end else begin
					frames_q <= cfg_data[pfm_pkg::CFG_FRAMES_W-1:0];
				end
			end
			// a new frame limit asks for a recount; the sweep takes the request
			if (cfg_we && (cfg_index == pfm_pkg::CFG_FRAMES)) begin
				pend_q <= 1'b1;
			end else if (pend_q && ((state_q == S_IDLE) || (state_q == S_SWEEP))) begin
				pend_q <= 1'b0;
			end
		end
	end

	// command payload through the steps
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tuser;
			pg_q   <= in_d.page;
			fr_q   <= in_d.frame;
			auto_q <= in_d.auto_frame;
		end
		if (state_q == S_FIND) begin
			pd_q     <= pv_q[pg_q] ? pfm_pkg::page_entry_t'(page_rdata) : '0;
			status_q <= st_find;
			tgt_q    <= tgt_find;
		end
		if (state_q == S_OWN) begin
			own_v_q  <= ovalid_q[tgt_q];
			own_pg_q <= own_rdata;
			vic_q    <= vic_own;
		end
		if (state_q == S_VICT) begin
			vd_q <= vic_q ? vunm : vraw;
			if (ok) begin
				pd_q <= pnew;
			end
		end
		if ((state_q == S_WRITE) && out_free) begin
			m_tdata_q <= res;
			m_tuser_q <= status_q;
		end
	end

endmodule

`default_nettype wire

### design/pfm_checker.sv
// Port-level checks of the page table and frame map, bound to the top level.
`default_nettype none

module pfm_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [pfm_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic [pfm_pkg::STATUS_W-1:0]   m_tuser
);

	pfm_pkg::out_data_t od;
	assign od = pfm_pkg::out_data_t'(m_tdata);

	// one command at a time: no accept on the beat after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while previous one in progress");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// an error beat carries nothing but its status and the free count
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != pfm_pkg::STAT_OK) |->
		(od.frame_out == '0) && (od.page_out == '0) && !od.mapped && !od.present &&
		!od.dirty && !od.referenced && (od.last_frame == '0) && !od.last_frame_valid)
		else $error("error beat carries page or frame data");

	// free count never exceeds the frame table
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(od.free_count) <= pfm_pkg::MAX_FRAMES))
		else $error("free count out of range");

	// last frame reads zero unless valid
	a_last_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !od.last_frame_valid |-> (od.last_frame == '0))
		else $error("last frame set without valid flag");

endmodule

bind page_frame_map_table pfm_checker u_pfm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
